// File: rtl/core/csfw_pkg.sv
// Shared types and codes for the counting semaphore with FIFO wait queue.
// Holds outcome codes, register indexes and the waiter entry layout.
// No dependencies.
`timescale 1ns / 1ps

package csfw_pkg;

   // Field widths fixed by the transaction format
   localparam int ID_W      = 8;
   localparam int PERMIT_W  = 16;
   localparam int OUTCOME_W = 3;
   localparam int CSR_IDX_W = 1;

   // Operation kinds on the request channel
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_GRANTED    = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_QUEUED     = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_WOKEN      = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_NONE_WOKEN = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_REJECTED   = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PERMIT_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_PERMITS = 1'd1;

   // One wait queue entry
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERMIT_W-1:0] need;
   } waiter_type;

endpackage

// File: rtl/core/counting_semaphore_fifo_waiters_top.sv
// Counting semaphore with permit limit and FIFO wait queue, top level.
// Depends on csfw_pkg for codes and the wait queue entry type.
`timescale 1ns / 1ps

// Usage:
//   req channel: one transaction per semaphore operation. tuser selects
//   acquire or release, tdata carries requester id and permit count.
//   rsp channel: one or more result transactions per request; tlast marks
//   the final one. tuser is the outcome code.
//   csr port: single-cycle writes, only while the block is idle. Writing
//   initial_permits loads the counter and empties the wait queue.
// Timing:
//   An acquire's result is loaded into the output register at the
//   accept edge. A release does the saturating add at accept, then the
//   compare/subtract unit checks the queue head; each wake passes through
//   a wait state before the next check, since the queue memory has one
//   registered read port at the head pointer.
//   One request is handled at a time; req_tready is low while a release
//   walks the queue.
// Reset: counter 0, limit 65535, queue empty; no clearing pass.
// Stall: a result waits in the output register while rsp_tready is low;
//   the walk holds until the register can take the next result.
module counting_semaphore_fifo_waiters_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] requester_id, [23:8] permit_count
   input  logic        req_tuser,   // [0] req_type
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] granted_id, [23:8] permits_left
   output logic [2:0]  rsp_tuser,   // [2:0] outcome
   output logic        rsp_tlast,   // last
   // Configuration port
   input  logic        csr_we,
   input  logic [csfw_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   localparam int PW = csfw_pkg::PERMIT_W;
   localparam int IW = csfw_pkg::ID_W;
   localparam int OW = csfw_pkg::OUTCOME_W;

   // Control registers
   logic [1:0]       state_ff, state_in;
   logic [PW-1:0]    counter_ff, counter_in;
   logic [PW-1:0]    limit_ff, limit_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [IW-1:0]    pend_id_ff, pend_id_in;
   logic [PW-1:0]    pend_left_ff, pend_left_in;
   logic [OW-1:0]    rsp_outcome_ff, rsp_outcome_in;
   logic [IW-1:0]    rsp_id_ff, rsp_id_in;
   logic [PW-1:0]    rsp_left_ff, rsp_left_in;
   logic             rsp_last_ff, rsp_last_in;

   // Wait queue memory
   csfw_pkg::waiter_type queue_mem [QUEUE_DEPTH];
   csfw_pkg::waiter_type head_rd_ff;
   logic                 mem_we;
   csfw_pkg::waiter_type mem_wdata;

   logic             req_fire;
   logic             slot_free;
   logic [IW-1:0]    req_id;
   logic [PW-1:0]    req_cnt;
   logic [PW:0]      rel_sum;
   logic             wake;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;

   assign req_id     = req_tdata[IW-1:0];
   assign req_cnt    = req_tdata[IW+PW-1:IW];
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign rel_sum    = {1'b0, counter_ff} + {1'b0, req_cnt};
   assign head_next  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;

   // Compare: does the head waiter fit in the counter
   assign wake = (counter_ff != '0) && (count_ff != '0) && (counter_ff >= head_rd_ff.need);

   // Sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      counter_in     = counter_ff;
      limit_in       = limit_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      pend_in        = pend_ff;
      pend_id_in     = pend_id_ff;
      pend_left_in   = pend_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_wdata.id   = req_id;
      mem_wdata.need = req_cnt;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               unique case (csr_addr)
                  csfw_pkg::REG_PERMIT_LIMIT: limit_in = csr_wdata;
                  csfw_pkg::REG_INITIAL_PERMITS: begin
                     counter_in = csr_wdata;
                     head_in    = '0;
                     tail_in    = '0;
                     count_in   = '0;
                  end
                  default: ;
               endcase
            end
            if (req_fire) begin
               if (req_tuser == csfw_pkg::OP_ACQUIRE) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = req_id;
                  rsp_last_in  = 1'b1;
                  if (counter_ff >= req_cnt) begin
                     counter_in     = counter_ff - req_cnt;
                     rsp_outcome_in = csfw_pkg::OUT_GRANTED;
                     rsp_left_in    = counter_ff - req_cnt;
                  end else if (count_ff < CNT_FULL) begin
                     mem_we         = 1'b1;
                     tail_in        = tail_next;
                     count_in       = count_ff + 1'b1;
                     rsp_outcome_in = csfw_pkg::OUT_QUEUED;
                     rsp_left_in    = counter_ff;
                  end else begin
                     rsp_outcome_in = csfw_pkg::OUT_REJECTED;
                     rsp_left_in    = counter_ff;
                  end
               end else begin
                  // Saturating add, clamps a counter left above a lowered limit
                  counter_in = (rel_sum > {1'b0, limit_ff}) ? limit_ff : rel_sum[PW-1:0];
                  pend_in    = 1'b0;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // Results go out one behind, so last is known when emitted
            if (slot_free || !pend_ff) begin
               if (wake) begin
                  if (pend_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = csfw_pkg::OUT_WOKEN;
                     rsp_id_in      = pend_id_ff;
                     rsp_left_in    = pend_left_ff;
                     rsp_last_in    = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_id_in   = head_rd_ff.id;
                  pend_left_in = counter_ff - head_rd_ff.need;
                  counter_in   = counter_ff - head_rd_ff.need;
                  head_in      = head_next;
                  count_in     = count_ff - 1'b1;
                  state_in     = ST_WAIT;
               end else if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  if (pend_ff) begin
                     rsp_outcome_in = csfw_pkg::OUT_WOKEN;
                     rsp_id_in      = pend_id_ff;
                     rsp_left_in    = pend_left_ff;
                  end else begin
                     rsp_outcome_in = csfw_pkg::OUT_NONE_WOKEN;
                     rsp_id_in      = '0;
                     rsp_left_in    = counter_ff;
                  end
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WAIT: begin
            // Let the head read settle after the pointer moved
            state_in = ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         limit_ff     <= '1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_id_ff     <= pend_id_in;
      pend_left_ff   <= pend_left_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Queue memory: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[tail_ff] <= mem_wdata;
      end
      head_rd_ff <= queue_mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_left_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_outcome_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("wait queue count above depth");

   a_wait_to_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |=> state_ff == ST_CHECK)
      else $error("wait state did not return to check");

   a_wake_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && wake && (slot_free || !pend_ff))
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("wake did not pop the queue");

   a_not_last_woken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> rsp_outcome_ff == csfw_pkg::OUT_WOKEN)
      else $error("non-final result is not a wake");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff != ST_IDLE)
      else $error("pending wake left while idle");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for counting_semaphore_fifo_waiters_top.
// Tracks permits and the wait queue in a scoreboard class and checks every result.
// Depends on csfw_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int QUEUE_DEPTH = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam int IW = csfw_pkg::ID_W;
   localparam int PW = csfw_pkg::PERMIT_W;
   localparam int OW = csfw_pkg::OUTCOME_W;
   localparam int AW = csfw_pkg::CSR_IDX_W;

   typedef struct packed {
      logic [OW-1:0] outcome;
      logic [IW-1:0] id;
      logic [PW-1:0] left;
      logic          last;
   } sem_result_type;

   // Scoreboard: mirrors the permit counter and the wait queue
   class permit_tracker;
      logic [PW-1:0]        limit;
      logic [PW-1:0]        permits;
      csfw_pkg::waiter_type waiters[$];
      sem_result_type       pending_results[$];
      int unsigned          errors;

      function new();
         limit   = '1;
         permits = '0;
         errors  = 0;
      endfunction

      function void write_reg(logic [AW-1:0] idx, logic [PW-1:0] val);
         if (idx == csfw_pkg::REG_PERMIT_LIMIT) begin
            limit = val;
         end else if (idx == csfw_pkg::REG_INITIAL_PERMITS) begin
            permits = val;
            waiters.delete();
         end
      endfunction

      function void add_result(logic [OW-1:0] outcome, logic [IW-1:0] id);
         sem_result_type r;
         r.outcome = outcome;
         r.id      = id;
         r.left    = permits;
         r.last    = 1'b0;
         pending_results.push_back(r);
      endfunction

      // Work out the results of one accepted request
      function void note_request(logic op, logic [IW-1:0] id, logic [PW-1:0] cnt);
         int unsigned          sum;
         int                   woken;
         csfw_pkg::waiter_type w;
         woken = 0;
         if (op == csfw_pkg::OP_ACQUIRE) begin
            if (permits >= cnt) begin
               permits = permits - cnt;
               add_result(csfw_pkg::OUT_GRANTED, id);
            end else if (waiters.size() < QUEUE_DEPTH) begin
               w.id   = id;
               w.need = cnt;
               waiters.push_back(w);
               add_result(csfw_pkg::OUT_QUEUED, id);
            end else begin
               add_result(csfw_pkg::OUT_REJECTED, id);
            end
         end else begin
            // Saturating add, then wake heads in order while they fit
            sum = permits + cnt;
            if (sum > limit) sum = limit;
            permits = sum[PW-1:0];
            while (permits != 0 && waiters.size() != 0 && permits >= waiters[0].need) begin
               w = waiters.pop_front();
               permits = permits - w.need;
               add_result(csfw_pkg::OUT_WOKEN, w.id);
               woken++;
            end
            if (woken == 0) add_result(csfw_pkg::OUT_NONE_WOKEN, '0);
         end
         pending_results[pending_results.size()-1].last = 1'b1;
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(sem_result_type got);
         sem_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: outcome %0d id %0d permits_left %0d last %0b",
                   got.outcome, got.id, got.left, got.last);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", want.outcome, got.outcome);
            errors++;
         end
         if (got.id !== want.id) begin
            $error("granted_id mismatch: expected %0d, actual %0d", want.id, got.id);
            errors++;
         end
         if (got.left !== want.left) begin
            $error("permits_left mismatch: expected %0d, actual %0d", want.left, got.left);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [23:0]   req_tdata  = '0;
   logic          req_tuser  = csfw_pkg::OP_ACQUIRE;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [23:0]   rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_we     = 1'b0;
   logic [AW-1:0] csr_addr   = csfw_pkg::REG_PERMIT_LIMIT;
   logic [15:0]   csr_wdata  = '0;

   permit_tracker tracker = new();

   int send_idle_pct = 36;
   int recv_idle_pct = 61;
   int hold_requests = 0;

   counting_semaphore_fifo_waiters_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // [7:0] requester_id, [23:8] permit_count
      .req_tuser (req_tuser),   // [0] req_type
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // [7:0] granted_id, [23:8] permits_left
      .rsp_tuser (rsp_tuser),   // [2:0] outcome
      .rsp_tlast (rsp_tlast),   // last
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #(5_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: check each transaction, then drive ready with stalls and hold-offs
   initial begin : result_side
      int hold_left;
      int hold_served;
      sem_result_type got;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.outcome = rsp_tuser;
            got.id      = rsp_tdata[7:0];
            got.left    = rsp_tdata[23:8];
            got.last    = rsp_tlast;
            tracker.check_result(got);
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one request, with a random gap first, and hold it until accepted
   task automatic send_request(logic op, logic [IW-1:0] id, logic [PW-1:0] cnt);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {cnt, id};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, id, cnt);
   endtask

   // Wait for all results and the tail of any walk, then write both registers
   task automatic drain_and_configure(logic [15:0] limit_val, logic [15:0] initial_val);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= csfw_pkg::REG_PERMIT_LIMIT;
      csr_wdata <= limit_val;
      @(posedge clock);
      tracker.write_reg(csfw_pkg::REG_PERMIT_LIMIT, limit_val);
      csr_addr  <= csfw_pkg::REG_INITIAL_PERMITS;
      csr_wdata <= initial_val;
      @(posedge clock);
      tracker.write_reg(csfw_pkg::REG_INITIAL_PERMITS, initial_val);
      csr_we    <= 1'b0;
   endtask

   // Mostly counts near the working range, sometimes anything
   function automatic logic [PW-1:0] pick_count(int unsigned scale);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return PW'($urandom_range(0, scale));
      if (r < 92) return PW'($urandom_range(0, (scale * 8 > 65535) ? 65535 : scale * 8));
      return PW'($urandom_range(0, 65535));
   endfunction

   task automatic run_random(int count, int unsigned scale);
      logic op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < 55) ? csfw_pkg::OP_ACQUIRE : csfw_pkg::OP_RELEASE;
         send_request(op, IW'($urandom_range(0, 255)), pick_count(scale));
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero acquire, release on empty counter, widest request woken by widest release
      send_request(csfw_pkg::OP_ACQUIRE, 8'h00, 16'd0);
      send_request(csfw_pkg::OP_RELEASE, 8'h00, 16'd0);
      send_request(csfw_pkg::OP_ACQUIRE, 8'hFF, 16'hFFFF);
      send_request(csfw_pkg::OP_RELEASE, 8'h00, 16'hFFFF);
      // Fill the wait queue, overflow it once, then wake every waiter in one release
      for (int i = 0; i <= QUEUE_DEPTH; i++)
         send_request(csfw_pkg::OP_ACQUIRE, IW'(8'hA0 + i), 16'd100);
      send_request(csfw_pkg::OP_RELEASE, 8'h3C, 16'd1600);

      // Counter left above a lowered limit gets clamped by the next release
      drain_and_configure(16'd50, 16'd1000);
      send_request(csfw_pkg::OP_RELEASE, 8'h00, 16'd0);
      send_request(csfw_pkg::OP_ACQUIRE, 8'h11, 16'd50);

      // Zero limit: release leaves counter at zero, waiter not examined
      drain_and_configure(16'd0, 16'hFFFF);
      send_request(csfw_pkg::OP_ACQUIRE, 8'h22, 16'hFFFF);
      send_request(csfw_pkg::OP_ACQUIRE, 8'h33, 16'd1);
      send_request(csfw_pkg::OP_RELEASE, 8'h44, 16'hFFFF);

      // Random traffic, sender idles less than receiver
      drain_and_configure(16'd200, 16'd20);
      run_random(135, 40);

      // Random traffic, idling swapped
      drain_and_configure(16'hFFFF, 16'd0);
      send_idle_pct = 61;
      recv_idle_pct = 36;
      run_random(135, 1500);

      // Full rate, starting with a long receiver hold-off to back up the request side
      drain_and_configure(16'd1000, 16'd500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      run_random(135, 120);

      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
